### hw/rtl/handheld_memory_map_bank_controller_defines.svh
// Assertion macros for the memory map controller
`ifndef HANDHELD_MEMORY_MAP_BANK_CONTROLLER_DEFINES_SVH
`define HANDHELD_MEMORY_MAP_BANK_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define HMM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hmm_pkg.sv
`default_nettype none
package hmm_pkg;

    localparam int STORE_DEPTH   = 32768;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int ROM_BANK_BITS = 7;
    localparam int EXT_W         = 21;

    localparam logic [1:0] KIND_ROM  = 2'd0;
    localparam logic [1:0] KIND_MBC1 = 2'd1;
    localparam logic [1:0] KIND_MBC2 = 2'd2;
    localparam logic [1:0] KIND_MBC3 = 2'd3;

    localparam logic [2:0] SRC_INTERNAL = 3'd0;
    localparam logic [2:0] SRC_ROM      = 3'd1;
    localparam logic [2:0] SRC_BOOT     = 3'd2;
    localparam logic [2:0] SRC_RAM_RD   = 3'd3;
    localparam logic [2:0] SRC_RAM_WR   = 3'd4;
    localparam logic [2:0] SRC_NONE     = 3'd5;

    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;
    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_DMA  = 16'hFF46;
    localparam logic [15:0] ADDR_BOOT = 16'hFF50;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0]       read_data;
        logic [2:0]       source;
        logic [EXT_W-1:0] ext_address;
        logic             timer_load;
        logic [10:0]      timer_value;
        logic             dma_start;
        logic [7:0]       dma_page;
    } rsp_t;

    function automatic logic [10:0] reload_of(input logic [1:0] f);
        logic [10:0] r;
        unique case (f)
            2'd0: r = 11'd1024;
            2'd1: r = 11'd16;
            2'd2: r = 11'd64;
            2'd3: r = 11'd256;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/hmm_ifs.sv
`default_nettype none
interface hmm_req_if import hmm_pkg::*;;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hmm_rsp_if import hmm_pkg::*;;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hmm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/handheld_memory_map_bank_controller.sv
// Channel | Dir | Payload
// req     | in  | opcode, address, write_data
// rsp     | out | read_data, source, ext_address, timer/dma side outputs
// cfg     | in  | controller_kind
// After reset a clearing pass zeroes every store entry, req held off.
// Response valid the cycle after accept; a store read passes through ST_READ first (the RAM read is registered).
// One request is in flight; the next is taken the cycle after the response is taken.
// cfg is always ready; controller_kind is registered whenever cfg.valid is high.
`default_nettype none
`include "handheld_memory_map_bank_controller_defines.svh"
module handheld_memory_map_bank_controller import hmm_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hmm_req_if.sink    req,
    hmm_rsp_if.source  rsp,
    hmm_cfg_if.sink    cfg
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [STORE_AW:0]      clr_reg;
    logic [1:0]             kind_reg;
    logic [6:0]             rom_bank_reg, rom_bank_next;
    logic [1:0]             ram_bank_reg, ram_bank_next;
    logic                   ram_en_reg, ram_en_next;
    logic                   mode_reg, mode_next;
    logic                   boot_done_reg, boot_done_next;
    logic [1:0]             tac_reg, tac_next;
    logic [2:0]             stat_reg, stat_next;
    logic                   out_valid_reg;
    rsp_t                   rsp_reg, rsp_next;

    logic                   mem_we;
    logic [STORE_AW-1:0]    mem_addr, acc_addr;
    logic [7:0]             mem_wdata, acc_wdata, mem_rdata;
    logic                   acc_we, acc_rd;

    logic                   accept;
    logic                   is_wr, raw, blocked, en;
    logic [15:0]            addr, a;
    logic [7:0]             d;
    logic [8:0]             bank;
    logic [22:0]            rom_ext;
    logic [EXT_W-1:0]       ram_ext;

    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    assign is_wr = req.payload.opcode[0];
    assign raw   = req.payload.opcode[1];
    assign addr  = req.payload.address;
    assign d     = req.payload.write_data;
    assign en    = (d[3:0] == 4'hA);
    assign a     = (addr >= 16'hE000 && addr < 16'hFE00) ? addr - 16'h2000 : addr;

    always_comb
    begin
        if (addr < 16'h4000)
        begin
            bank = (kind_reg == KIND_MBC1 && mode_reg) ? {2'b0, ram_bank_reg, 5'b0} : 9'd0;
        end
        else
        begin
            unique case (kind_reg)
                KIND_MBC1: bank = {2'b0, ram_bank_reg, rom_bank_reg[4:0]};
                KIND_MBC2: bank = {5'b0, rom_bank_reg[3:0]};
                KIND_MBC3: bank = {2'b0, rom_bank_reg};
                default:   bank = 9'd1;
            endcase
        end
        bank    = bank & 9'((1 << ROM_BANK_BITS) - 1);
        rom_ext = {bank, addr[13:0]};
        if (kind_reg == KIND_MBC2)
        begin
            ram_ext = EXT_W'(addr[8:0]);
        end
        else if (kind_reg == KIND_MBC1 && !mode_reg)
        begin
            ram_ext = EXT_W'(addr[12:0]);
        end
        else
        begin
            ram_ext = EXT_W'({ram_bank_reg, addr[12:0]});
        end
    end

    always_comb
    begin
        rsp_next       = '0;
        rom_bank_next  = rom_bank_reg;
        ram_bank_next  = ram_bank_reg;
        ram_en_next    = ram_en_reg;
        mode_next      = mode_reg;
        boot_done_next = boot_done_reg;
        tac_next       = tac_reg;
        stat_next      = stat_reg;
        acc_we         = 1'b0;
        acc_rd         = 1'b0;
        acc_addr       = a[STORE_AW-1:0];
        acc_wdata      = d;
        blocked        = 1'b0;
        if (!raw)
        begin
            if (addr < 16'hA000)
            begin
                blocked = (stat_reg[1:0] == 2'd3);
            end
            else if (addr >= 16'hFE00 && addr < 16'hFEA0)
            begin
                blocked = stat_reg[1];
            end
        end
        priority if (addr < 16'h8000)
        begin
            if (is_wr)
            begin
                rsp_next.source = SRC_NONE;
                if (!raw && kind_reg != KIND_ROM)
                begin
                    priority if (addr >= 16'h6000)
                    begin
                        mode_next = d[0];
                    end
                    else if (kind_reg == KIND_MBC2)
                    begin
                        if (addr < 16'h4000)
                        begin
                            if (addr[8])
                            begin
                                rom_bank_next = (d[3:0] == 4'd0) ? 7'd1 : {3'b0, d[3:0]};
                            end
                            else
                            begin
                                ram_en_next = en;
                            end
                        end
                    end
                    else if (addr < 16'h2000)
                    begin
                        ram_en_next = en;
                    end
                    else if (addr < 16'h4000)
                    begin
                        if (kind_reg == KIND_MBC1)
                        begin
                            rom_bank_next = (d[4:0] == 5'd0) ? 7'd1 : {2'b0, d[4:0]};
                        end
                        else
                        begin
                            rom_bank_next = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
                        end
                    end
                    else
                    begin
                        ram_bank_next = d[1:0];
                    end
                end
            end
            else if (!boot_done_reg && addr < 16'h0100)
            begin
                rsp_next.source      = SRC_BOOT;
                rsp_next.ext_address = EXT_W'(addr);
            end
            else
            begin
                rsp_next.source      = SRC_ROM;
                rsp_next.ext_address = rom_ext[EXT_W-1:0];
            end
        end
        else if (addr >= 16'hA000 && addr < 16'hC000)
        begin
            if (raw || ram_en_reg)
            begin
                rsp_next.source      = is_wr ? SRC_RAM_WR : SRC_RAM_RD;
                rsp_next.ext_address = ram_ext;
            end
            else
            begin
                rsp_next.source    = SRC_NONE;
                rsp_next.read_data = is_wr ? 8'h00 : 8'hFF;
            end
        end
        else if (blocked)
        begin
            rsp_next.source    = SRC_NONE;
            rsp_next.read_data = is_wr ? 8'h00 : 8'hFF;
        end
        else if (!is_wr)
        begin
            acc_rd = 1'b1;
        end
        else
        begin
            acc_we = 1'b1;
            if (!raw)
            begin
                priority if (a == ADDR_TAC)
                begin
                    if (tac_reg != d[1:0])
                    begin
                        rsp_next.timer_load  = 1'b1;
                        rsp_next.timer_value = reload_of(d[1:0]);
                    end
                end
                else if (a == ADDR_DIV || a == ADDR_LY)
                begin
                    acc_wdata = 8'h00;
                end
                else if (a == ADDR_LCDC)
                begin
                    acc_wdata = d | 8'h80;
                end
                else if (a == ADDR_STAT)
                begin
                    acc_wdata = {d[7:3], stat_reg};
                end
                else if (a == ADDR_DMA)
                begin
                    rsp_next.dma_start = 1'b1;
                    rsp_next.dma_page  = d;
                end
                else if (a == ADDR_BOOT)
                begin
                    boot_done_next = 1'b1;
                end
                else
                begin
                end
            end
            if (a == ADDR_TAC)
            begin
                tac_next = acc_wdata[1:0];
            end
            if (a == ADDR_STAT)
            begin
                stat_next = acc_wdata[2:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg[STORE_AW]) state_next = ST_IDLE;
            ST_IDLE:  if (accept && acc_rd) state_next = ST_READ;
            ST_READ:  state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = !clr_reg[STORE_AW];
            mem_addr  = clr_reg[STORE_AW-1:0];
            mem_wdata = 8'h00;
        end
        else
        begin
            mem_we    = accept && acc_we;
            mem_addr  = acc_addr;
            mem_wdata = acc_wdata;
        end
    end

    hmm_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            kind_reg      <= KIND_ROM;
            rom_bank_reg  <= 7'd1;
            ram_bank_reg  <= 2'd0;
            ram_en_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            boot_done_reg <= 1'b0;
            tac_reg       <= 2'd0;
            stat_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR && !clr_reg[STORE_AW])
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg.valid)
            begin
                kind_reg <= cfg.data;
            end
            if (accept)
            begin
                rom_bank_reg  <= rom_bank_next;
                ram_bank_reg  <= ram_bank_next;
                ram_en_reg    <= ram_en_next;
                mode_reg      <= mode_next;
                boot_done_reg <= boot_done_next;
                tac_reg       <= tac_next;
                stat_reg      <= stat_next;
            end
            if (accept && !acc_rd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_READ)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
        else if (state_reg == ST_READ)
        begin
            rsp_reg.read_data <= mem_rdata;
        end
    end

    `HMM_ASSERT_SAME(a_ready_no_pending, req.ready, !out_valid_reg && state_reg == ST_IDLE, "ready while busy")
    `HMM_ASSERT_NEXT(a_read_waits, accept && acc_rd, state_reg == ST_READ && !out_valid_reg, "store read did not wait")
    `HMM_ASSERT_NEXT(a_read_delivers, state_reg == ST_READ, out_valid_reg, "store read lost")
    `HMM_ASSERT_NEXT(a_clear_holds, state_reg == ST_CLEAR && !clr_reg[STORE_AW], !out_valid_reg, "response during clear")

endmodule
`default_nettype wire

### hw/rtl/hmm_ram.sv
`default_nettype none
module hmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire
